// ----- hw/rtl/gkpe_pkg.sv -----
// ============================================================================
// gkpe_pkg
// Shared types, widths and constants of the gapped k-mer pair extractor.
// ============================================================================
package gkpe_pkg;

    localparam int CHAR_W         = 8;
    localparam int CODE_W         = 3;
    localparam int KMER_W         = 64;
    localparam int LEADER_LEN_W   = 6;
    localparam int GAP_LEN_W      = 7;
    localparam int FOLLOWER_LEN_W = 6;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 4;
    localparam int REG_IDX_W      = 2;

    localparam int DEF_MAX_KMER  = 32;
    localparam int DEF_MAX_DELAY = 128;

    localparam logic [LEADER_LEN_W-1:0]   LEADER_LEN_RST   = 6'd27;
    localparam logic [GAP_LEN_W-1:0]      GAP_LEN_RST      = 7'd0;
    localparam logic [FOLLOWER_LEN_W-1:0] FOLLOWER_LEN_RST = 6'd27;

    localparam logic [CODE_W-1:0] BASE_A       = 3'd0;
    localparam logic [CODE_W-1:0] BASE_C       = 3'd1;
    localparam logic [CODE_W-1:0] BASE_G       = 3'd2;
    localparam logic [CODE_W-1:0] BASE_T       = 3'd3;
    localparam logic [CODE_W-1:0] INVALID_CODE = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_LEADER_LEN   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAP_LEN      = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FOLLOWER_LEN = 2'd2;

    typedef struct packed {
        logic step;
        logic clear;
    } t_step_ctl;

    typedef struct packed {
        logic [KMER_W-1:0] leader_kmer;
        logic [KMER_W-1:0] follower_kmer;
    } t_kmer_pair;

    function automatic logic [CODE_W-1:0] base_code(input logic [CHAR_W-1:0] c);
        logic [CODE_W-1:0] code;
        case (c) inside
            8'h41, 8'h61: code = BASE_A;
            8'h43, 8'h63: code = BASE_C;
            8'h47, 8'h67: code = BASE_G;
            8'h54, 8'h74: code = BASE_T;
            default:      code = INVALID_CODE;
        endcase
        return code;
    endfunction

endpackage

// ----- hw/rtl/gkpe_if.sv -----
// ============================================================================
// gkpe_if
// Valid/ready channels: base requests in, k-mer pair requests out.
// ============================================================================
interface gkpe_base_if;
    logic                        valid;
    logic                        ready;
    logic [gkpe_pkg::CHAR_W-1:0] base_char;
    logic                        read_end;

    modport source (output valid, output base_char, output read_end, input ready);
    modport sink   (input valid, input base_char, input read_end, output ready);
endinterface

interface gkpe_kmer_if;
    logic                        valid;
    logic                        ready;
    logic [gkpe_pkg::KMER_W-1:0] leader_kmer;
    logic [gkpe_pkg::KMER_W-1:0] follower_kmer;

    modport source (output valid, output leader_kmer, output follower_kmer, input ready);
    modport sink   (input valid, input leader_kmer, input follower_kmer, output ready);
endinterface

// ----- hw/rtl/gapped_kmer_pair_extractor_core.sv -----
// ============================================================================
// gapped_kmer_pair_extractor_core
// Gapped k-mer pair extractor: leader/follower k-mers from a streamed read.
// ============================================================================
// Takes ASCII bases and, when both k-mers hold a full run of valid bases,
// writes both k-mers into the output buffer. The leader is fed from a row of
// MAX_DELAY delay cells tapped at follower_length + gap_length; each k-mer is
// a shift row with a run counter, so every base completes in the accept cycle
// and one base per clock is sustained while the output buffer has room. Its
// two entries keep the input open while a result waits; input ready drops
// only when both entries are held. Reset and an accepted read_end clear the
// delay line and k-mers with no clearing pass. Lengths of 0 act as 1, lengths
// above MAX_KMER as MAX_KMER, and the total delay is capped at MAX_DELAY.
// Registers: leader_length at 0x0, gap_length at 0x4, follower_length at 0x8;
// write them only while no base is in flight.
// ============================================================================
module gapped_kmer_pair_extractor_core #(
    parameter int MAX_KMER  = gkpe_pkg::DEF_MAX_KMER,
    parameter int MAX_DELAY = gkpe_pkg::DEF_MAX_DELAY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gkpe_base_if.sink                         i_base,
    gkpe_kmer_if.source                       o_kmer,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gkpe_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gkpe_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gkpe_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int RUN_W  = $clog2(MAX_KMER + 1);
    localparam int IDX_W  = $clog2(MAX_DELAY);
    localparam int DLY_W  = $clog2(MAX_DELAY + 1);
    localparam int DSUM_W = (DLY_W > 8) ? DLY_W : 8;
    localparam int CODE_W = gkpe_pkg::CODE_W;

    // configuration
    logic [gkpe_pkg::LEADER_LEN_W-1:0]   r_leader_len;
    logic [gkpe_pkg::GAP_LEN_W-1:0]      r_gap_len;
    logic [gkpe_pkg::FOLLOWER_LEN_W-1:0] r_follower_len;
    logic [gkpe_pkg::REG_IDX_W-1:0]      w_reg_idx;
    logic                                w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[gkpe_pkg::REG_IDX_W+1:2];
    assign w_cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leader_len   <= gkpe_pkg::LEADER_LEN_RST;
            r_gap_len      <= gkpe_pkg::GAP_LEN_RST;
            r_follower_len <= gkpe_pkg::FOLLOWER_LEN_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                gkpe_pkg::REG_LEADER_LEN: begin
                    r_leader_len <= pwdata[gkpe_pkg::LEADER_LEN_W-1:0];
                end
                gkpe_pkg::REG_GAP_LEN: begin
                    r_gap_len <= pwdata[gkpe_pkg::GAP_LEN_W-1:0];
                end
                gkpe_pkg::REG_FOLLOWER_LEN: begin
                    r_follower_len <= pwdata[gkpe_pkg::FOLLOWER_LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            gkpe_pkg::REG_LEADER_LEN:   prdata = gkpe_pkg::APB_DATA_W'(r_leader_len);
            gkpe_pkg::REG_GAP_LEN:      prdata = gkpe_pkg::APB_DATA_W'(r_gap_len);
            gkpe_pkg::REG_FOLLOWER_LEN: prdata = gkpe_pkg::APB_DATA_W'(r_follower_len);
            default:                    prdata = '0;
        endcase
    end

    // effective lengths and delay tap
    logic [RUN_W-1:0]  w_llen;
    logic [RUN_W-1:0]  w_flen;
    logic [DSUM_W-1:0] w_dsum;
    logic [DSUM_W-1:0] w_delay;
    logic [IDX_W-1:0]  w_tap_idx;

    always_comb begin
        if (r_leader_len == '0) begin
            w_llen = RUN_W'(1);
        end else if (r_leader_len > gkpe_pkg::LEADER_LEN_W'(MAX_KMER)) begin
            w_llen = RUN_W'(MAX_KMER);
        end else begin
            w_llen = RUN_W'(r_leader_len);
        end
        if (r_follower_len == '0) begin
            w_flen = RUN_W'(1);
        end else if (r_follower_len > gkpe_pkg::FOLLOWER_LEN_W'(MAX_KMER)) begin
            w_flen = RUN_W'(MAX_KMER);
        end else begin
            w_flen = RUN_W'(r_follower_len);
        end
        w_dsum    = DSUM_W'(w_flen) + DSUM_W'(r_gap_len);
        w_delay   = (w_dsum > DSUM_W'(MAX_DELAY)) ? DSUM_W'(MAX_DELAY) : w_dsum;
        w_tap_idx = IDX_W'(w_delay - 1'b1);
    end

    // input step
    logic                 w_accept;
    logic [CODE_W-1:0]    w_code;
    gkpe_pkg::t_step_ctl  w_ctl;
    logic                 r_v0;
    logic                 r_v1;

    assign i_base.ready = ~r_v1;
    assign w_accept     = i_base.valid & i_base.ready;
    assign w_code       = gkpe_pkg::base_code(i_base.base_char);
    assign w_ctl.step   = w_accept;
    assign w_ctl.clear  = i_base.read_end;

    // delay line
    logic [CODE_W-1:0]    w_chain [MAX_DELAY+1];
    logic [CODE_W-1:0]    w_tap   [MAX_DELAY];
    logic [MAX_DELAY-1:0] w_tap_bit [CODE_W];
    logic [CODE_W-1:0]    w_delayed;

    assign w_chain[0] = w_code;

    for (genvar i = 0; i < MAX_DELAY; i++) begin : g_cell
        gkpe_delay_cell #(
            .INDEX (i),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_code    (w_chain[i]),
            .i_tap_idx (w_tap_idx),
            .o_code    (w_chain[i+1]),
            .o_tap     (w_tap[i])
        );
        for (genvar b = 0; b < CODE_W; b++) begin : g_bit
            assign w_tap_bit[b][i] = w_tap[i][b];
        end
    end

    for (genvar b = 0; b < CODE_W; b++) begin : g_or
        assign w_delayed[b] = |w_tap_bit[b];
    end

    // k-mers
    logic                        w_lead_full;
    logic                        w_fol_full;
    logic [gkpe_pkg::KMER_W-1:0] w_lead_kmer;
    logic [gkpe_pkg::KMER_W-1:0] w_fol_kmer;

    gkpe_kmer_unit #(
        .MAX_KMER (MAX_KMER),
        .RUN_W    (RUN_W)
    ) u_leader (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_code  (w_delayed),
        .i_len   (w_llen),
        .o_full  (w_lead_full),
        .o_kmer  (w_lead_kmer)
    );

    gkpe_kmer_unit #(
        .MAX_KMER (MAX_KMER),
        .RUN_W    (RUN_W)
    ) u_follower (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_code  (w_code),
        .i_len   (w_flen),
        .o_full  (w_fol_full),
        .o_kmer  (w_fol_kmer)
    );

    // two-entry output buffer
    gkpe_pkg::t_kmer_pair r_q0;
    gkpe_pkg::t_kmer_pair r_q1;
    gkpe_pkg::t_kmer_pair w_new;
    logic                 w_push;
    logic                 w_pop;

    assign w_new.leader_kmer   = w_lead_kmer;
    assign w_new.follower_kmer = w_fol_kmer;
    assign w_push = w_accept & w_lead_full & w_fol_full;
    assign w_pop  = r_v0 & o_kmer.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            case ({w_push, w_pop})
                2'b10: begin
                    if (!r_v0) begin
                        r_v0 <= 1'b1;
                    end else begin
                        r_v1 <= 1'b1;
                    end
                end
                2'b01: begin
                    r_v0 <= r_v1;
                    r_v1 <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case ({w_push, w_pop})
            2'b10: begin
                if (!r_v0) begin
                    r_q0 <= w_new;
                end else begin
                    r_q1 <= w_new;
                end
            end
            2'b01: begin
                r_q0 <= r_q1;
            end
            2'b11: begin
                if (r_v1) begin
                    r_q0 <= r_q1;
                    r_q1 <= w_new;
                end else begin
                    r_q0 <= w_new;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_kmer.valid         = r_v0;
    assign o_kmer.leader_kmer   = r_q0.leader_kmer;
    assign o_kmer.follower_kmer = r_q0.follower_kmer;

endmodule

// ----- hw/rtl/gkpe_delay_cell.sv -----
// ============================================================================
// gkpe_delay_cell
// One stage of the base delay line: holds a code, passes it on, drives its tap.
// ============================================================================
module gkpe_delay_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gkpe_pkg::t_step_ctl           i_ctl,
    input  logic [gkpe_pkg::CODE_W-1:0]   i_code,
    input  logic [IDX_W-1:0]              i_tap_idx,
    output logic [gkpe_pkg::CODE_W-1:0]   o_code,
    output logic [gkpe_pkg::CODE_W-1:0]   o_tap
);

    logic [gkpe_pkg::CODE_W-1:0] r_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= gkpe_pkg::INVALID_CODE;
        end else if (i_ctl.step) begin
            r_code <= i_ctl.clear ? gkpe_pkg::INVALID_CODE : i_code;
        end
    end

    assign o_code = r_code;
    assign o_tap  = (i_tap_idx == IDX_W'(INDEX)) ? r_code : '0;

endmodule

// ----- hw/rtl/gkpe_kmer_unit.sv -----
// ============================================================================
// gkpe_kmer_unit
// Sliding k-mer: row of 2-bit base slots, valid run counter, length mask.
// ============================================================================
module gkpe_kmer_unit #(
    parameter int MAX_KMER = gkpe_pkg::DEF_MAX_KMER,
    parameter int RUN_W    = $clog2(MAX_KMER + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gkpe_pkg::t_step_ctl           i_ctl,
    input  logic [gkpe_pkg::CODE_W-1:0]   i_code,
    input  logic [RUN_W-1:0]              i_len,
    output logic                          o_full,
    output logic [gkpe_pkg::KMER_W-1:0]   o_kmer
);

    localparam int SHIFT_W = 2 * MAX_KMER;

    logic [SHIFT_W-1:0] r_shift;
    logic [SHIFT_W-1:0] n_shift;
    logic [RUN_W-1:0]   r_run;
    logic [RUN_W-1:0]   n_run;
    logic [SHIFT_W-1:0] w_masked;
    logic               w_valid;

    assign w_valid = ~i_code[gkpe_pkg::CODE_W-1];

    always_comb begin
        if (w_valid) begin
            n_shift = (r_shift << 2) | SHIFT_W'(i_code[1:0]);
            n_run   = (r_run == RUN_W'(MAX_KMER)) ? r_run : r_run + 1'b1;
        end else begin
            n_shift = '0;
            n_run   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_run   <= '0;
        end else if (i_ctl.step) begin
            r_shift <= i_ctl.clear ? '0 : n_shift;
            r_run   <= i_ctl.clear ? '0 : n_run;
        end
    end

    for (genvar b = 0; b < MAX_KMER; b++) begin : g_slot
        assign w_masked[2*b +: 2] = (RUN_W'(b) < i_len) ? n_shift[2*b +: 2] : 2'b00;
    end

    assign o_full = (n_run >= i_len);
    assign o_kmer = gkpe_pkg::KMER_W'(w_masked);

endmodule

// ----- hw/rtl/gkpe_checker.sv -----
// ============================================================================
// gkpe_checker
// Port-level checks of the extractor's flow control and output buffering.
// ============================================================================
module gkpe_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [gkpe_pkg::KMER_W-1:0]   i_out_leader,
    input logic [gkpe_pkg::KMER_W-1:0]   i_out_follower
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_leader) && $stable(i_out_follower))
        else $error("stalled result changed");

    a_ready_low_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input blocked with no pending result");

    a_ready_fall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_in_valid && i_out_valid && !i_out_ready))
        else $error("input ready dropped without a stalled result");

    a_result_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready))
        else $error("result without an accepted base");

endmodule

bind gapped_kmer_pair_extractor_core gkpe_checker u_gkpe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_base.valid),
    .i_in_ready     (i_base.ready),
    .i_out_valid    (o_kmer.valid),
    .i_out_ready    (o_kmer.ready),
    .i_out_leader   (o_kmer.leader_kmer),
    .i_out_follower (o_kmer.follower_kmer)
);
